/* rtl/sssd_pkg.sv */
// Shared types, register codes and the segment table of the seven-segment scan driver.
`default_nettype none
package sssd_pkg;

  localparam int DIGIT_COUNT_DEFAULT     = 4;
  localparam int FRACTION_DIGITS_DEFAULT = 2;

  localparam int VALUE_W     = 16;
  localparam int DWELL_W     = 8;
  localparam int SEG_W       = 7;
  localparam int DRIVE_W     = 4;
  localparam int NUMBER_W    = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int QUEUE_DEPTH = 4;

  // Reciprocal of ten: (x * RECIP_10) >> RECIP_SHIFT equals x / 10 for every 16-bit x.
  localparam logic [16:0] RECIP_10    = 17'd52429;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [DWELL_W-1:0] MUX_TICKS_RESET = 8'd5;

  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_MUX_TICKS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POLARITY  = 1'd1;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value_hundredths;
  } item_t;

  typedef struct packed {
    logic [SEG_W-1:0]    segment_drive;
    logic                point_drive;
    logic [DRIVE_W-1:0]  digit_drive;
    logic [NUMBER_W-1:0] digit_number;
  } result_t;

  // Segments a..g on bits 0..6, lit is 1.
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
    logic [SEG_W-1:0] pattern;
    case (digit)
      4'd0:    pattern = 7'h3F;
      4'd1:    pattern = 7'h06;
      4'd2:    pattern = 7'h5B;
      4'd3:    pattern = 7'h4F;
      4'd4:    pattern = 7'h66;
      4'd5:    pattern = 7'h6D;
      4'd6:    pattern = 7'h7D;
      4'd7:    pattern = 7'h07;
      4'd8:    pattern = 7'h7F;
      4'd9:    pattern = 7'h6F;
      default: pattern = 7'h00;
    endcase
    return pattern;
  endfunction

endpackage
`default_nettype wire

/* rtl/seven_segment_scan_driver.sv */
// Top level of the multiplexed seven-segment scan driver.
// An accepted item passes one splitter stage per decimal digit, then the queue and
// the result register. Throughput: one item per cycle while results are popped;
// the result register refills in the cycle it is popped.
// Reset (synchronous, active high) clears digits, scan position, dwell count and
// queues, and loads mux_ticks = 5 and common cathode polarity.
`default_nettype none
module seven_segment_scan_driver #(
  parameter int DIGIT_COUNT     = sssd_pkg::DIGIT_COUNT_DEFAULT,
  parameter int FRACTION_DIGITS = sssd_pkg::FRACTION_DIGITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire sssd_pkg::item_t                  item,
  output logic                                  empty,
  input  wire logic                             pop,
  output sssd_pkg::result_t                     result,
  input  wire logic                             cfg_we,
  input  wire logic [sssd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sssd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int MW = 4 * DIGIT_COUNT + 1;

  logic          split_valid;
  logic          split_ready;
  logic [MW-1:0] split_data;
  logic          back_valid;
  logic          back_ready;
  logic [MW-1:0] back_data;

  sssd_split #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_split (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .out_valid(split_valid),
    .out_ready(split_ready),
    .out_data (split_data)
  );

  sssd_fifo #(
    .WIDTH(MW),
    .DEPTH(sssd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(split_valid),
    .push_ready(split_ready),
    .push_data (split_data),
    .pop_valid (back_valid),
    .pop_ready (back_ready),
    .pop_data  (back_data)
  );

  sssd_scan #(
    .DIGIT_COUNT    (DIGIT_COUNT),
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (back_valid),
    .in_ready (back_ready),
    .in_data  (back_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

`ifndef SYNTHESIS
  // The front end only pushes back when its last stage holds a beat the queue cannot take.
  assert property (@(posedge clk) disable iff (rst) full |-> (split_valid && !split_ready))
    else $error("full raised without a stalled beat at the end of the splitter");

  // A beat taken by the scan engine is always shown on the next cycle.
  assert property (@(posedge clk) disable iff (rst) (back_valid && back_ready) |=> !empty)
    else $error("beat taken from the queue did not produce a result");

  // Popping the last result with nothing behind it leaves the output empty.
  assert property (@(posedge clk) disable iff (rst) (pop && !empty && !back_valid) |=> empty)
    else $error("result still shown after its beat was popped");

  // Reset leaves both sides idle.
  assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("block not idle after reset");
`endif

endmodule
`default_nettype wire

/* rtl/sssd_split.sv */
// Front end: accepts items and splits their values into decimal digits, one digit per stage.
`default_nettype none
module sssd_split #(
  parameter int DIGIT_COUNT = sssd_pkg::DIGIT_COUNT_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  output logic                         full,
  input  wire sssd_pkg::item_t         item,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [4*DIGIT_COUNT:0]       out_data
);

  localparam int DW   = 4 * DIGIT_COUNT;
  localparam int VW   = sssd_pkg::VALUE_W;
  localparam int LAST = DIGIT_COUNT - 1;

  logic [DIGIT_COUNT-1:0] vld;
  logic [DIGIT_COUNT-1:0] kind;
  logic [VW-1:0]          rem      [LAST];
  logic [DW-1:0]          digs     [DIGIT_COUNT];

  logic [VW-1:0]          src      [DIGIT_COUNT];
  logic [VW+17-1:0]       prod     [DIGIT_COUNT];
  logic [VW-1:0]          quo      [DIGIT_COUNT];
  logic [3:0]             diff     [DIGIT_COUNT];
  logic [DW-1:0]          digs_next[DIGIT_COUNT];
  logic                   adv;

  // The whole pipeline moves together; it only stops when its last stage cannot hand off.
  assign adv       = !vld[LAST] || out_ready;
  assign full      = !adv;
  assign out_valid = vld[LAST];
  assign out_data  = {kind[LAST], digs[LAST]};

  always_comb begin
    src[0]       = item.value_hundredths;
    digs_next[0] = '0;
    for (int s = 1; s < DIGIT_COUNT; s++) begin
      src[s]       = rem[s-1];
      digs_next[s] = digs[s-1];
    end
    // Stage s peels off the s-th least significant digit, which lands in nibble s.
    for (int s = 0; s < DIGIT_COUNT; s++) begin
      prod[s] = (VW+17)'(src[s]) * (VW+17)'(sssd_pkg::RECIP_10);
      quo[s]  = VW'(prod[s] >> sssd_pkg::RECIP_SHIFT);
      diff[s] = 4'(src[s] - ((quo[s] << 3) + (quo[s] << 1)));
      digs_next[s][4*s +: 4] = diff[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DIGIT_COUNT-2:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind <= {kind[DIGIT_COUNT-2:0], item.kind};
      for (int s = 0; s < LAST; s++) begin
        rem[s] <= quo[s];
      end
      for (int s = 0; s < DIGIT_COUNT; s++) begin
        digs[s] <= digs_next[s];
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/sssd_fifo.sv */
// Short queue between the digit splitter and the scan engine.
`default_nettype none
module sssd_fifo #(
  parameter int WIDTH = 17,
  parameter int DEPTH = sssd_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/sssd_scan.sv */
// Back end: digit store, dwell counter, scan position, drive patterns and result register.
`default_nettype none
module sssd_scan #(
  parameter int DIGIT_COUNT     = sssd_pkg::DIGIT_COUNT_DEFAULT,
  parameter int FRACTION_DIGITS = sssd_pkg::FRACTION_DIGITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [4*DIGIT_COUNT:0]           in_data,
  input  wire logic                             cfg_we,
  input  wire logic [sssd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sssd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                  empty,
  input  wire logic                             pop,
  output sssd_pkg::result_t                     result
);

  localparam int DW          = 4 * DIGIT_COUNT;
  localparam int SCAN_W      = $clog2(DIGIT_COUNT);
  localparam int WW          = sssd_pkg::DWELL_W;
  localparam int POINT_INDEX = DIGIT_COUNT - 1 - FRACTION_DIGITS;

  logic [3:0]          store      [DIGIT_COUNT];
  logic [3:0]          store_next [DIGIT_COUNT];
  logic [SCAN_W-1:0]   scan_pos;
  logic [SCAN_W-1:0]   scan_pos_next;
  logic [SCAN_W-1:0]   scan_step;
  logic [WW-1:0]       dwell;
  logic [WW-1:0]       dwell_next;
  logic [WW-1:0]       dwell_inc;
  logic [WW-1:0]       limit;
  logic [WW-1:0]       mux_ticks;
  logic                anode_mode;
  logic                res_vld;
  logic                take;
  logic                wrap;
  logic [3:0]          digit;
  logic [sssd_pkg::SEG_W-1:0]   seg;
  logic                         pt;
  logic [sssd_pkg::DRIVE_W-1:0] sel;
  logic [31:0]                  pos_wide;
  sssd_pkg::result_t            result_next;

  assign in_ready = !res_vld || pop;
  assign take     = in_valid && in_ready;
  assign empty    = !res_vld;

  always_comb begin
    limit     = (mux_ticks == '0) ? WW'(1) : mux_ticks;
    dwell_inc = dwell + WW'(1);
    wrap      = (dwell_inc >= limit);
    scan_step = (scan_pos == SCAN_W'(DIGIT_COUNT - 1)) ? '0 : scan_pos + SCAN_W'(1);
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      store_next[i] = store[i];
    end
    dwell_next    = dwell;
    scan_pos_next = scan_pos;
    if (in_data[DW] == sssd_pkg::KIND_TICK) begin
      dwell_next    = wrap ? '0 : dwell_inc;
      scan_pos_next = wrap ? scan_step : scan_pos;
    end else begin
      // Digit 0 is the most significant and sits in the top nibble.
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        store_next[i] = in_data[4*(DIGIT_COUNT-1-i) +: 4];
      end
    end
  end

  always_comb begin
    digit    = store_next[scan_pos_next];
    seg      = sssd_pkg::seg_pattern(digit);
    pos_wide = 32'(scan_pos_next);
    pt       = (POINT_INDEX >= 0) && (pos_wide == 32'(POINT_INDEX));
    for (int j = 0; j < sssd_pkg::DRIVE_W; j++) begin
      sel[j] = (pos_wide == 32'(j));
    end
    if (anode_mode) begin
      result_next.segment_drive = ~seg;
      result_next.point_drive   = !pt;
      result_next.digit_drive   = sel;
    end else begin
      result_next.segment_drive = seg;
      result_next.point_drive   = pt;
      result_next.digit_drive   = ~sel;
    end
    result_next.digit_number = pos_wide[sssd_pkg::NUMBER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mux_ticks  <= sssd_pkg::MUX_TICKS_RESET;
      anode_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sssd_pkg::REG_MUX_TICKS: mux_ticks  <= cfg_data;
        sssd_pkg::REG_POLARITY:  anode_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        store[i] <= '0;
      end
      scan_pos <= '0;
      dwell    <= '0;
      res_vld  <= 1'b0;
    end else begin
      if (take) begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          store[i] <= store_next[i];
        end
        scan_pos <= scan_pos_next;
        dwell    <= dwell_next;
        res_vld  <= 1'b1;
      end else if (pop) begin
        res_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

/* bench/seven_segment_scan_driver_tb.sv */
// Testbench for the seven-segment scan driver: directed and random beats against a predictor.
`timescale 1ns / 1ps
module seven_segment_scan_driver_tb;

  localparam int IDLE_LIMIT = 4000;
  localparam int NDIG       = sssd_pkg::DIGIT_COUNT_DEFAULT;
  localparam int POINT_POS  = NDIG - 1 - sssd_pkg::FRACTION_DIGITS_DEFAULT;

  typedef struct {
    sssd_pkg::item_t   beat;
    bit                typed;
    sssd_pkg::result_t want;
  } directed_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             push = 1'b0;
  logic                             full;
  sssd_pkg::item_t                  item_beat = '0;
  logic                             empty;
  logic                             pop = 1'b0;
  sssd_pkg::result_t                drive_out;
  logic                             cfg_we = 1'b0;
  logic [sssd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [sssd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Own copy of the display state and the registers.
  logic [3:0]                   shown_digit [NDIG];
  logic [1:0]                   scan_pos;
  logic [sssd_pkg::DWELL_W-1:0] dwell;
  logic [sssd_pkg::DWELL_W-1:0] mux_ticks_cfg;
  logic                         anode_cfg;

  sssd_pkg::result_t pending_drive [$];
  int      error_count = 0;
  int      beats_sent = 0;
  int      drives_seen = 0;
  int      burst_left = 0;
  int      idle_cycles = 0;

  const logic [sssd_pkg::SEG_W-1:0] SEG_LUT [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                                     7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

  directed_row_t directed_rows [25] = '{
    '{'{sssd_pkg::KIND_SET,  16'd0},     1'b1, '{7'h3F, 1'b0, 4'b1110, 2'd0}},
    '{'{sssd_pkg::KIND_SET,  16'd65535}, 1'b1, '{7'h6D, 1'b0, 4'b1110, 2'd0}},
    '{'{sssd_pkg::KIND_SET,  16'd10000}, 1'b1, '{7'h3F, 1'b0, 4'b1110, 2'd0}},
    '{'{sssd_pkg::KIND_SET,  16'd9999},  1'b1, '{7'h6F, 1'b0, 4'b1110, 2'd0}},
    '{'{sssd_pkg::KIND_TICK, 16'hFFFF},  1'b0, '0},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b0, '0},
    '{'{sssd_pkg::KIND_TICK, 16'hAAAA},  1'b0, '0},
    '{'{sssd_pkg::KIND_TICK, 16'h5555},  1'b0, '0},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b1, '{7'h6F, 1'b1, 4'b1101, 2'd1}},
    '{'{sssd_pkg::KIND_SET,  16'd8765},  1'b1, '{7'h07, 1'b1, 4'b1101, 2'd1}},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b0, '0},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b0, '0},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b0, '0},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b0, '0},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b1, '{7'h7D, 1'b0, 4'b1011, 2'd2}},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b0, '0},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b0, '0},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b0, '0},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b0, '0},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b1, '{7'h6D, 1'b0, 4'b0111, 2'd3}},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b0, '0},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b0, '0},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b0, '0},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b0, '0},
    '{'{sssd_pkg::KIND_TICK, 16'h0000},  1'b1, '{7'h7F, 1'b0, 4'b1110, 2'd0}}
  };

  seven_segment_scan_driver DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item_beat),
    .empty     (empty),
    .pop       (pop),
    .result    (drive_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void reset_display_model();
    foreach (shown_digit[i]) shown_digit[i] = 4'd0;
    scan_pos      = 2'd0;
    dwell         = '0;
    mux_ticks_cfg = sssd_pkg::MUX_TICKS_RESET;
    anode_cfg     = 1'b0;
  endfunction

  // Applies one beat to the display state and returns the drive it should produce.
  function automatic sssd_pkg::result_t predict_drive(input sssd_pkg::item_t beat);
    int unsigned       v;
    int unsigned       limit;
    sssd_pkg::result_t drive;
    logic [3:0]        sel;
    if (beat.kind == sssd_pkg::KIND_SET) begin
      v = beat.value_hundredths;
      for (int i = 0; i < NDIG; i++) begin
        shown_digit[NDIG - 1 - i] = 4'(v % 10);
        v = v / 10;
      end
    end else begin
      limit = (mux_ticks_cfg == 0) ? 1 : mux_ticks_cfg;
      dwell = dwell + 1'b1;
      if (dwell >= limit) begin
        dwell    = '0;
        scan_pos = scan_pos + 1'b1;
      end
    end
    sel = 4'b0001 << scan_pos;
    drive.segment_drive = SEG_LUT[shown_digit[scan_pos]];
    drive.point_drive   = (scan_pos == POINT_POS);
    drive.digit_number  = scan_pos;
    if (anode_cfg) begin
      drive.segment_drive = ~drive.segment_drive;
      drive.point_drive   = ~drive.point_drive;
      drive.digit_drive   = sel;
    end else begin
      drive.digit_drive   = ~sel;
    end
    return drive;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < 40)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_drive(input sssd_pkg::result_t got);
    sssd_pkg::result_t want;
    if (pending_drive.size() == 0) begin
      report_mismatch("unexpected beat", got, 0);
    end else begin
      want = pending_drive.pop_front();
      if (got.segment_drive !== want.segment_drive)
        report_mismatch("segment_drive", got.segment_drive, want.segment_drive);
      if (got.point_drive !== want.point_drive)
        report_mismatch("point_drive", got.point_drive, want.point_drive);
      if (got.digit_drive !== want.digit_drive)
        report_mismatch("digit_drive", got.digit_drive, want.digit_drive);
      if (got.digit_number !== want.digit_number)
        report_mismatch("digit_number", got.digit_number, want.digit_number);
    end
  endtask

  // Result side and watchdog, both sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (pop && !empty) begin
        check_drive(drive_out);
        drives_seen++;
      end
      if ((pop && !empty) || (push && !full)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("seven_segment_scan_driver_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The receiver changes its stall style every so often, from no stalls to long stalls.
  initial begin
    int stall_mode;
    int phase_cnt;
    stall_mode = 0;
    phase_cnt  = 0;
    forever begin
      @(negedge clk);
      if (phase_cnt % 96 == 0) stall_mode = $urandom_range(0, 3);
      phase_cnt++;
      if (rst) begin
        pop <= 1'b0;
      end else begin
        case (stall_mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= ((phase_cnt % 8) < 2);
          default: pop <= ((phase_cnt % 32) == 0);
        endcase
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input sssd_pkg::item_t beat, input bit typed,
                           input sssd_pkg::result_t want);
    sssd_pkg::result_t predicted;
    push      <= 1'b1;
    item_beat <= beat;
    @(posedge clk);
    while (full) @(posedge clk);
    predicted = predict_drive(beat);
    pending_drive.push_back(typed ? want : predicted);
    beats_sent++;
    @(negedge clk);
  endtask

  // Sender pacing: bursts of back-to-back beats separated by random gaps.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk);
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sssd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [sssd_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == sssd_pkg::REG_MUX_TICKS) mux_ticks_cfg = data;
    else                                anode_cfg     = data[0];
    @(negedge clk);
  endtask

  function automatic sssd_pkg::item_t make_beat(input int tick_pct);
    sssd_pkg::item_t beat;
    beat.kind = ($urandom_range(0, 99) < tick_pct) ? sssd_pkg::KIND_TICK : sssd_pkg::KIND_SET;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       beat.value_hundredths = 16'd0;
        1:       beat.value_hundredths = 16'd9999;
        2:       beat.value_hundredths = 16'd10000;
        default: beat.value_hundredths = 16'hFFFF;
      endcase
    end else begin
      beat.value_hundredths = 16'($urandom_range(0, 65535));
    end
    return beat;
  endfunction

  task automatic run_phase(input int beats, input int tick_pct);
    for (int n = 0; n < beats; n++) begin
      pace_sender();
      send_beat(make_beat(tick_pct), 1'b0, '0);
    end
    wait_drained();
  endtask

  task automatic set_polarity(input logic anode);
    write_reg(sssd_pkg::REG_POLARITY, {7'($urandom_range(0, 127)), anode});
  endtask

  initial begin
    logic [sssd_pkg::CFG_DATA_W-1:0] mux;
    reset_display_model();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table under reset settings.
    foreach (directed_rows[r]) begin
      pace_sender();
      send_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want);
    end
    wait_drained();

    // Fastest scan with common anode.
    write_reg(sssd_pkg::REG_MUX_TICKS, 8'd1);
    set_polarity(1'b1);
    run_phase(200, 60);

    // Slowest scan; mostly ticks so the dwell count climbs high.
    write_reg(sssd_pkg::REG_MUX_TICKS, 8'd255);
    set_polarity(1'b0);
    run_phase(240, 95);

    // Dwell now sits above the new setting, so the first tick must advance.
    write_reg(sssd_pkg::REG_MUX_TICKS, 8'd3);
    set_polarity(1'b1);
    run_phase(200, 60);

    // Zero behaves like one.
    write_reg(sssd_pkg::REG_MUX_TICKS, 8'd0);
    set_polarity(1'b0);
    run_phase(200, 60);

    for (int p = 0; p < 8; p++) begin
      mux = (p % 4 == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 6));
      write_reg(sssd_pkg::REG_MUX_TICKS, mux);
      set_polarity(1'($urandom_range(0, 1)));
      run_phase(100, $urandom_range(40, 85));
    end

    $display("Sent %0d beats over 13 register settings, %0d drive beats checked.",
             beats_sent, drives_seen);
    $display("Covered scan periods 0, 1, 3, 255 and random, both polarities, value wrap.");
    if (error_count == 0) begin
      $display("seven_segment_scan_driver_tb: clean");
    end else begin
      $display("seven_segment_scan_driver_tb: errors");
    end
    $finish;
  end

endmodule

/* seven_segment_scan_driver.f */
rtl/sssd_pkg.sv
rtl/sssd_split.sv
rtl/sssd_fifo.sv
rtl/sssd_scan.sv
rtl/seven_segment_scan_driver.sv
bench/seven_segment_scan_driver_tb.sv
